// ===== src/cssw_pkg.sv =====
// Package for the comment-stripping word splitter.
// Holds scan modes, result kinds, character codes and the request types.
// No dependencies; imported by cssw_core and the top level, not by the interfaces.
package cssw_pkg;

  typedef enum logic [1:0] {
    MODE_OUT    = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] character;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic       push;
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

// ===== src/cssw_in_if.sv =====
// Input channel of the comment-stripping word splitter.
// Carries one source byte or an end-of-stream marker per request; uses no package.
interface cssw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_stream;

  modport source (output valid, output text_byte, output end_of_stream, input ready);
  modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

// ===== src/cssw_out_if.sv =====
// Result channel of the comment-stripping word splitter.
// Carries one word character, word end or discard marker per request; uses no package.
interface cssw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] character;
  logic       last_of_run;

  modport source (output valid, output kind, output character, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input character, input last_of_run,
                  output ready);
endinterface

// ===== src/cssw_core.sv =====
// Input register, scanner state and the per-byte scanning step.
// Produces up to two results per byte for the result queue; depends on cssw_pkg.
module cssw_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_end_of_stream,
  input  logic                room,
  output cssw_pkg::step_t     step
);
  import cssw_pkg::*;

  logic       v_r;
  logic [7:0] byte_r;
  logic       eos_r;
  logic       adv;

  mode_t mode_r, mode_nxt;
  logic  slash_r, slash_nxt;
  logic  star_r, star_nxt;
  logic  word_r, word_nxt;

  assign adv      = v_r && room;
  assign in_ready = !v_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r <= in_text_byte;
      eos_r  <= in_end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OUT;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      word_r  <= 1'b0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
      word_r  <= word_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    slash_nxt  = slash_r;
    star_nxt   = (byte_r == CH_STAR);
    word_nxt   = word_r;
    step.push  = adv;
    step.count = 2'd0;
    step.res0  = '{kind: KIND_CHAR, character: 8'h00, last_of_run: 1'b0};
    step.res1  = '{kind: KIND_CHAR, character: 8'h00, last_of_run: 1'b0};
    if (eos_r) begin
      if (word_r || slash_r) begin
        step.count = 2'd1;
        step.res0  = '{kind: KIND_DROP, character: 8'h00, last_of_run: 1'b1};
      end
      mode_nxt  = MODE_OUT;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
      word_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_OUT: begin
          if (slash_r && (byte_r == CH_SLASH || byte_r == CH_STAR)) begin
            slash_nxt = 1'b0;
            mode_nxt  = (byte_r == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          end else if (is_blank(byte_r)) begin
            if (slash_r) begin
              step.count = 2'd2;
              step.res0  = '{kind: KIND_CHAR, character: CH_SLASH, last_of_run: 1'b0};
              step.res1  = '{kind: KIND_END, character: 8'h00, last_of_run: 1'b1};
            end else if (word_r) begin
              step.count = 2'd1;
              step.res0  = '{kind: KIND_END, character: 8'h00, last_of_run: 1'b1};
            end
            slash_nxt = 1'b0;
            word_nxt  = 1'b0;
          end else if (byte_r == CH_QUOTE) begin
            if (slash_r) begin
              step.count = 2'd1;
              step.res0  = '{kind: KIND_CHAR, character: CH_SLASH, last_of_run: 1'b1};
              word_nxt   = 1'b1;
            end
            slash_nxt = 1'b0;
            mode_nxt  = MODE_STRING;
          end else if (byte_r == CH_SLASH) begin
            slash_nxt = 1'b1;
          end else begin
            if (slash_r) begin
              step.count = 2'd2;
              step.res0  = '{kind: KIND_CHAR, character: CH_SLASH, last_of_run: 1'b0};
              step.res1  = '{kind: KIND_CHAR, character: byte_r, last_of_run: 1'b1};
            end else begin
              step.count = 2'd1;
              step.res0  = '{kind: KIND_CHAR, character: byte_r, last_of_run: 1'b1};
            end
            slash_nxt = 1'b0;
            word_nxt  = 1'b1;
          end
        end
        MODE_LINE: begin
          if (byte_r == CH_NL) begin
            mode_nxt = MODE_OUT;
          end
        end
        MODE_BLOCK: begin
          if (byte_r == CH_SLASH && star_r) begin
            mode_nxt = MODE_OUT;
          end
        end
        MODE_STRING: begin
          if (byte_r == CH_QUOTE) begin
            mode_nxt = MODE_OUT;
          end
        end
        default: begin
          mode_nxt = MODE_OUT;
        end
      endcase
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && eos_r |=> mode_r == MODE_OUT && !slash_r && !word_r && !star_r)
    else $error("end of stream did not clear the scanner state");

  a_slash_only_outside: assert property (@(posedge clk) disable iff (!rst_n)
    slash_r |-> mode_r == MODE_OUT)
    else $error("held slash outside plain text");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mode_r) && $stable(slash_r) && $stable(word_r))
    else $error("scanner state moved without a byte being processed");

endmodule

// ===== src/comment_stripping_word_splitter.sv =====
// Channel   Dir  Payload                               Request when
// in_ch     in   text_byte[7:0], end_of_stream         valid && ready
// out_ch    out  kind[1:0], character[7:0], last_of_run valid && ready
//
// One byte a cycle while the queue has room: a byte is registered, scanned
// there and its zero, one or two results go into a four-entry result queue.
// A byte leaves the input register only when the queue has two free entries,
// so a slow sink holds the byte there and stalls the input channel.
// Reset (rst_n low, synchronous) empties both stages and clears the scanner.
// Top level; depends on cssw_pkg, cssw_in_if, cssw_out_if and cssw_core.
module comment_stripping_word_splitter (
  input logic      clk,
  input logic      rst_n,
  cssw_in_if.sink    in_ch,
  cssw_out_if.source out_ch
);
  import cssw_pkg::*;

  step_t            step;
  logic             room;
  logic             pop;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [1:0]       push_n;
  result_t          oq_r [OQ_DEPTH];

  cssw_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_text_byte     (in_ch.text_byte),
    .in_end_of_stream (in_ch.end_of_stream),
    .room             (room),
    .step             (step)
  );

  assign room    = (cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign pop     = out_ch.valid && out_ch.ready;
  assign push_n  = step.push ? step.count : 2'd0;
  assign cnt_nxt = cnt_r + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_r + OQ_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + OQ_AW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq_r[wr_ptr_r] <= step.res0;
    end
    if (push_n == 2'd2) begin
      oq_r[wr_ptr_r + OQ_AW'(1)] <= step.res1;
    end
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.kind        = oq_r[rd_ptr_r].kind;
  assign out_ch.character   = oq_r[rd_ptr_r].character;
  assign out_ch.last_of_run = oq_r[rd_ptr_r].last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue overflow");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> !step.res0.last_of_run && step.res1.last_of_run)
    else $error("two-result request marked wrongly");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd1 |-> step.res0.last_of_run)
    else $error("single result not marked as last");

endmodule
